/* hw/rtl/pwt_pkg.sv */
// Shared constants and codes for the perceptron weight table.
package pwt_pkg;

    // Defaults for the top-level parameters
    localparam int LABEL_COUNT_DEF    = 32;
    localparam int TEMPLATE_COUNT_DEF = 1024;
    localparam int WEIGHT_BITS_DEF    = 32;

    // Fixed field widths
    localparam int ACTION_BITS   = 2;
    localparam int TEMPLATE_BITS = 10;
    localparam int LABEL_BITS    = 5;
    localparam int DELTA_BITS    = 32;
    localparam int SCORE_BITS    = 32;
    localparam int CNT_BITS      = 16;
    localparam int ACC_BITS      = 64;
    localparam int ORDER_BITS    = 2;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_READ_EM  = 2'd0,
        ACT_UPD_EM   = 2'd1,
        ACT_READ_TR  = 2'd2,
        ACT_UPD_TR   = 2'd3
    } t_action;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FILTER_ON  = 2'd0,
        CFG_TRAIN_DONE = 2'd1,
        CFG_THRESHOLD  = 2'd2,
        CFG_ORDER      = 2'd3
    } t_cfg_index;

endpackage

/* hw/rtl/perceptron_weight_table.sv */
// Top level of the perceptron weight table: emission and transition weight stores.
//
// Weight store for a structured perceptron tagger. An item is taken when start is
// high and busy is low; a read (emission or transition sum) gives one score on
// o_score, marked by o_valid for exactly one cycle, and an update gives nothing.
// The receiver cannot hold a result off, so it must take o_score whenever o_valid
// is high. Each table lives in one RAM whose word packs a weight and its 16-bit
// update counter; every touched entry is read, then modified and written back in
// the following cycle while the next entry is being read. An item keeps busy high
// until each entry it touches is written back: one entry for emission actions,
// and for transition actions one, two or three for context_order 0, 1 and 2 (or 3).
// The next start is only taken back in the idle state, so a new item waits until
// the last one is done; each table has a single RAM read port. Results appear the
// cycle after the last entry is processed. After reset both RAMs are swept to zero,
// one entry per cycle, over as many entries as the larger table holds, that is
// max(TEMPLATE_COUNT*LABEL_COUNT, LABEL_COUNT^3+LABEL_COUNT^2+LABEL_COUNT) entries
// (33824 with default sizes); busy stays high until the sweep is done. The
// configuration registers may be written at any time, including during the sweep,
// but should only change while no item is in flight.
module perceptron_weight_table
    import pwt_pkg::*;
#(
    parameter int LABEL_COUNT    = LABEL_COUNT_DEF,
    parameter int TEMPLATE_COUNT = TEMPLATE_COUNT_DEF,
    parameter int WEIGHT_BITS    = WEIGHT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // item transfer
    input  logic                             start,
    output logic                             busy,
    input  logic [ACTION_BITS-1:0]           i_action,
    input  logic [TEMPLATE_BITS-1:0]         i_template_index,
    input  logic [LABEL_BITS-1:0]            i_cur_label,
    input  logic [LABEL_BITS-1:0]            i_prev_label,
    input  logic [LABEL_BITS-1:0]            i_prev_prev_label,
    input  logic signed [DELTA_BITS-1:0]     i_delta,
    // result transfer
    output logic                             o_valid,
    output logic signed [SCORE_BITS-1:0]     o_score,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]        i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]         i_cfg_data
);

    // Table geometry
    localparam int LL2       = LABEL_COUNT * LABEL_COUNT;
    localparam int LL3       = LL2 * LABEL_COUNT;
    localparam int EM_DEPTH  = TEMPLATE_COUNT * LABEL_COUNT;
    localparam int TR_DEPTH  = LL3 + LL2 + LABEL_COUNT;
    localparam int MAX_DEPTH = (EM_DEPTH > TR_DEPTH) ? EM_DEPTH : TR_DEPTH;
    localparam int EM_AW     = $clog2(EM_DEPTH);
    localparam int TR_AW     = $clog2(TR_DEPTH);
    localparam int AW        = $clog2(MAX_DEPTH);
    localparam int WORD_BITS = WEIGHT_BITS + CNT_BITS;
    // Width of the weight update sum, one bit over the wider operand
    localparam int SW        = ((WEIGHT_BITS > DELTA_BITS) ? WEIGHT_BITS : DELTA_BITS) + 1;

    localparam logic signed [WEIGHT_BITS-1:0] W_HI = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_LO = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] A_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] A_LO = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0] SC_HI =
        {{(ACC_BITS-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SC_LO =
        {{(ACC_BITS-SCORE_BITS+1){1'b1}}, {(SCORE_BITS-1){1'b0}}};
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN
    } t_state;

    // Weight plus delta, saturated to the weight range
    function automatic logic signed [WEIGHT_BITS-1:0] f_sat_weight(
        input logic signed [WEIGHT_BITS-1:0] w,
        input logic signed [DELTA_BITS-1:0]  d
    );
        logic signed [SW-1:0] s;
        s = SW'(w) + SW'(d);
        if (s > SW'(W_HI)) begin
            return W_HI;
        end else if (s < SW'(W_LO)) begin
            return W_LO;
        end
        return WEIGHT_BITS'(s);
    endfunction

    // Saturating accumulate at the accumulator width
    function automatic logic signed [ACC_BITS-1:0] f_sat_acc(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        logic signed [ACC_BITS:0] s;
        s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(b);
        if (s[ACC_BITS] != s[ACC_BITS-1]) begin
            return s[ACC_BITS] ? A_LO : A_HI;
        end
        return ACC_BITS'(s);
    endfunction

    function automatic logic signed [SCORE_BITS-1:0] f_clamp_score(
        input logic signed [ACC_BITS-1:0] a
    );
        if (a > SC_HI) begin
            return SC_HI[SCORE_BITS-1:0];
        end else if (a < SC_LO) begin
            return SC_LO[SCORE_BITS-1:0];
        end
        return a[SCORE_BITS-1:0];
    endfunction

    // Control and configuration
    t_state                      r_state;
    logic [AW-1:0]               r_clr_addr;
    logic                        r_filter_on;
    logic                        r_train_done;
    logic [CNT_BITS-1:0]         r_thr;
    logic [ORDER_BITS-1:0]       r_order;
    logic                        r_valid;
    logic signed [SCORE_BITS-1:0] r_score;

    // Item in flight
    logic                        r_is_em;
    logic                        r_is_upd;
    logic signed [DELTA_BITS-1:0] r_delta;
    logic [AW-1:0]               r_q_addr [3];
    logic [2:0]                  r_q_ok;
    logic [1:0]                  r_left;
    logic                        r_pend;
    logic [AW-1:0]               r_pend_addr;
    logic                        r_pend_ok;
    logic                        r_pend_last;
    logic signed [ACC_BITS-1:0]  r_acc;

    // Address build for the incoming item
    logic                        l_ok;
    logic                        p_ok;
    logic                        pp_ok;
    logic                        e_ok;
    logic                        use_bi;
    logic                        use_tri;
    logic [AW-1:0]               em_idx;
    logic [AW-1:0]               uni_idx;
    logic [AW-1:0]               bi_idx;
    logic [AW-1:0]               tri_idx;
    logic                        n_is_em;
    logic                        n_is_upd;

    // Read-modify-write datapath
    logic                        rd_issue;
    logic [WORD_BITS-1:0]        em_rdata;
    logic [WORD_BITS-1:0]        tr_rdata;
    logic [WORD_BITS-1:0]        rd_word;
    logic signed [WEIGHT_BITS-1:0] w_cur;
    logic [CNT_BITS-1:0]         c_cur;
    logic signed [WEIGHT_BITS-1:0] w_filt;
    logic signed [WEIGHT_BITS-1:0] w_new;
    logic [CNT_BITS-1:0]         c_new;
    logic signed [ACC_BITS-1:0]  n_acc;
    logic                        upd_we;
    logic                        clearing;
    logic                        em_we;
    logic                        tr_we;
    logic [AW-1:0]               wr_addr;
    logic [WORD_BITS-1:0]        wr_data;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_score = r_score;

    // Range checks and entry addresses; out-of-range entries point at 0
    always_comb begin
        l_ok    = 32'(i_cur_label) < 32'(LABEL_COUNT);
        p_ok    = 32'(i_prev_label) < 32'(LABEL_COUNT);
        pp_ok   = 32'(i_prev_prev_label) < 32'(LABEL_COUNT);
        e_ok    = l_ok && (32'(i_template_index) < 32'(TEMPLATE_COUNT));
        use_bi  = r_order[1] | r_order[0];
        use_tri = r_order[1];
        em_idx  = e_ok ? AW'(i_template_index) * AW'(LABEL_COUNT) + AW'(i_cur_label)
                       : '0;
        uni_idx = l_ok ? AW'(LL3 + LL2) + AW'(i_cur_label) : '0;
        bi_idx  = (l_ok && p_ok)
                ? AW'(LL3) + AW'(i_prev_label) * AW'(LABEL_COUNT) + AW'(i_cur_label)
                : '0;
        tri_idx = (l_ok && p_ok && pp_ok)
                ? AW'(i_prev_prev_label) * AW'(LL2)
                  + AW'(i_prev_label) * AW'(LABEL_COUNT) + AW'(i_cur_label)
                : '0;
        n_is_em  = 1'b0;
        n_is_upd = 1'b0;
        case (t_action'(i_action))
            ACT_READ_EM: begin
                n_is_em = 1'b1;
            end
            ACT_UPD_EM: begin
                n_is_em  = 1'b1;
                n_is_upd = 1'b1;
            end
            ACT_READ_TR: begin
                n_is_em = 1'b0;
            end
            ACT_UPD_TR: begin
                n_is_upd = 1'b1;
            end
            default: begin
                n_is_em = 1'b0;
            end
        endcase
    end

    // Entry read last cycle: filter for reads, bump for updates
    always_comb begin
        rd_issue = (r_state == S_RUN) && (r_left != 2'd0);
        rd_word  = r_is_em ? em_rdata : tr_rdata;
        w_cur    = rd_word[WEIGHT_BITS-1:0];
        c_cur    = rd_word[WORD_BITS-1:WEIGHT_BITS];
        if (!r_train_done && r_filter_on && (c_cur < r_thr)) begin
            w_filt = '0;
        end else begin
            w_filt = w_cur;
        end
        w_new = f_sat_weight(w_cur, r_delta);
        c_new = (r_filter_on && (c_cur != CNT_MAX)) ? c_cur + 1'b1 : c_cur;
        n_acc = r_pend_ok ? f_sat_acc(r_acc, ACC_BITS'(w_filt)) : r_acc;

        clearing = (r_state == S_CLEAR);
        upd_we   = (r_state == S_RUN) && r_pend && r_pend_ok && r_is_upd;
        if (clearing) begin
            em_we   = {1'b0, r_clr_addr} < (AW+1)'(EM_DEPTH);
            tr_we   = {1'b0, r_clr_addr} < (AW+1)'(TR_DEPTH);
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            em_we   = upd_we && r_is_em;
            tr_we   = upd_we && !r_is_em;
            wr_addr = r_pend_addr;
            wr_data = {c_new, w_new};
        end
    end

    pwt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (EM_DEPTH)
    ) u_em_ram (
        .i_clk   (i_clk),
        .i_we    (em_we),
        .i_waddr (wr_addr[EM_AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (rd_issue && r_is_em),
        .i_raddr (r_q_addr[0][EM_AW-1:0]),
        .o_rdata (em_rdata)
    );

    pwt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TR_DEPTH)
    ) u_tr_ram (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (wr_addr[TR_AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (rd_issue && !r_is_em),
        .i_raddr (r_q_addr[0][TR_AW-1:0]),
        .o_rdata (tr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_filter_on  <= 1'b0;
            r_train_done <= 1'b0;
            r_thr        <= '0;
            r_order      <= '0;
            r_valid      <= 1'b0;
            r_left       <= '0;
            r_pend       <= 1'b0;
        end else begin
            // strobe for one cycle once the last entry of a read is modified
            r_valid <= (r_state == S_RUN) && r_pend && r_pend_last && !r_is_upd;

            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_FILTER_ON:  r_filter_on  <= i_cfg_data[0];
                    CFG_TRAIN_DONE: r_train_done <= i_cfg_data[0];
                    CFG_THRESHOLD:  r_thr        <= i_cfg_data[CNT_BITS-1:0];
                    CFG_ORDER:      r_order      <= i_cfg_data[ORDER_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    // zero sweep over both tables
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if ({1'b0, r_clr_addr} == (AW+1)'(MAX_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_is_em  <= n_is_em;
                        r_is_upd <= n_is_upd;
                        r_delta  <= i_delta;
                        r_acc    <= '0;
                        r_state  <= S_RUN;
                        if (n_is_em) begin
                            r_q_addr[0] <= em_idx;
                            r_q_ok[0]   <= e_ok;
                            r_left      <= 2'd1;
                        end else begin
                            // unigram, bigram, trigram: the sum saturates in this order
                            r_q_addr[0] <= uni_idx;
                            r_q_ok[0]   <= l_ok;
                            r_left      <= 2'd1 + 2'(use_bi) + 2'(use_tri);
                        end
                        r_q_addr[1] <= bi_idx;
                        r_q_ok[1]   <= l_ok && p_ok;
                        r_q_addr[2] <= tri_idx;
                        r_q_ok[2]   <= l_ok && p_ok && pp_ok;
                    end
                end
                S_RUN: begin
                    // read side: shift the entry queue down
                    if (rd_issue) begin
                        r_q_addr[0] <= r_q_addr[1];
                        r_q_addr[1] <= r_q_addr[2];
                        r_q_ok[0]   <= r_q_ok[1];
                        r_q_ok[1]   <= r_q_ok[2];
                        r_left      <= r_left - 1'b1;
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_q_addr[0];
                        r_pend_ok   <= r_q_ok[0];
                        r_pend_last <= (r_left == 2'd1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                    // modify side: write-back happens through the RAM write port
                    if (r_pend) begin
                        r_acc <= n_acc;
                        if (r_pend_last) begin
                            r_state <= S_IDLE;
                            if (!r_is_upd) begin
                                r_score <= f_clamp_score(n_acc);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/pwt_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module pwt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the perceptron weight table: directed table and random phases.
module testbench;
    import pwt_pkg::*;

    // Table sizes follow the package defaults, which the instance below keeps.
    // With these sizes every 5-bit label and 10-bit template is a valid index,
    // so no out-of-range entry can be addressed from the ports.
    localparam int LBL      = LABEL_COUNT_DEF;
    localparam int TPL      = TEMPLATE_COUNT_DEF;
    localparam int EM_DEPTH = TPL * LBL;
    localparam int TR_BASE  = LBL * LBL * LBL;
    localparam int TR_DEPTH = TR_BASE + LBL * LBL + LBL;

    localparam longint Q_MAX = (longint'(1) <<< (WEIGHT_BITS_DEF - 1)) - 1;
    localparam longint Q_MIN = -Q_MAX - 1;

    localparam int CYCLE_LIMIT   = 300_000;     // clearing sweep + items, several times over
    localparam int DRAIN_CYCLES  = 8;           // covers the busy time of the longest item and its result
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 120;

    typedef struct {
        t_action                      act;
        logic [TEMPLATE_BITS-1:0]     tmpl;
        logic [LABEL_BITS-1:0]        cur;
        logic [LABEL_BITS-1:0]        prev;
        logic [LABEL_BITS-1:0]        pprev;
        logic signed [DELTA_BITS-1:0] delta;
    } t_table_op;

    // Directed rows: a register write, an item checked by the predictor, or a
    // read whose score is typed in. value is register data, delta or score.
    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_ITEM,
        STEP_CHECK
    } t_step_kind;

    typedef struct packed {
        t_step_kind               kind;
        t_cfg_index               idx;
        t_action                  act;
        logic [TEMPLATE_BITS-1:0] tmpl;
        logic [LABEL_BITS-1:0]    cur;
        logic [LABEL_BITS-1:0]    prev;
        logic [LABEL_BITS-1:0]    pprev;
        logic [31:0]              value;
    } t_step;

    localparam int DIRECTED_LEN = 35;
    localparam t_step DIRECTED [DIRECTED_LEN] = '{
        // freshly cleared tables read as zero
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'h0000_0000},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_TR, 10'd0,    5'd0,  5'd0,  5'd0,  32'h0000_0000},
        // emission weight saturates high, then low
        '{STEP_ITEM,  CFG_FILTER_ON, ACT_UPD_EM,  10'd1023, 5'd31, 5'd0,  5'd0,  32'h7FFF_FFFF},
        '{STEP_ITEM,  CFG_FILTER_ON, ACT_UPD_EM,  10'd1023, 5'd31, 5'd0,  5'd0,  32'h0000_0001},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_EM, 10'd1023, 5'd31, 5'd0,  5'd0,  32'h7FFF_FFFF},
        '{STEP_ITEM,  CFG_FILTER_ON, ACT_UPD_EM,  10'd0,    5'd0,  5'd0,  5'd0,  32'h8000_0000},
        '{STEP_ITEM,  CFG_FILTER_ON, ACT_UPD_EM,  10'd0,    5'd0,  5'd0,  5'd0,  32'hFFFF_FFFF},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'h8000_0000},
        // trigram order: three saturated contexts sum past the score range
        '{STEP_CFG,   CFG_ORDER,     ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'd2},
        '{STEP_ITEM,  CFG_FILTER_ON, ACT_UPD_TR,  10'd0,    5'd31, 5'd31, 5'd31, 32'h7FFF_FFFF},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_TR, 10'd0,    5'd31, 5'd31, 5'd31, 32'h7FFF_FFFF},
        '{STEP_ITEM,  CFG_FILTER_ON, ACT_UPD_TR,  10'd0,    5'd0,  5'd0,  5'd0,  32'h8000_0000},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_TR, 10'd0,    5'd0,  5'd0,  5'd0,  32'h8000_0000},
        // order three behaves as trigram
        '{STEP_CFG,   CFG_ORDER,     ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'd3},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_TR, 10'd0,    5'd31, 5'd31, 5'd31, 32'h7FFF_FFFF},
        '{STEP_CFG,   CFG_ORDER,     ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'd1},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_TR, 10'd0,    5'd31, 5'd31, 5'd0,  32'h7FFF_FFFF},
        // counting on: a weight stays hidden until its count reaches the threshold
        '{STEP_CFG,   CFG_FILTER_ON, ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'd1},
        '{STEP_CFG,   CFG_THRESHOLD, ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'd2},
        '{STEP_ITEM,  CFG_FILTER_ON, ACT_UPD_EM,  10'd5,    5'd3,  5'd0,  5'd0,  32'h0001_0000},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_EM, 10'd5,    5'd3,  5'd0,  5'd0,  32'h0000_0000},
        '{STEP_ITEM,  CFG_FILTER_ON, ACT_UPD_EM,  10'd5,    5'd3,  5'd0,  5'd0,  32'h0001_0000},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_EM, 10'd5,    5'd3,  5'd0,  5'd0,  32'h0002_0000},
        // updated while counting was off, so its count is still zero
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_EM, 10'd1023, 5'd31, 5'd0,  5'd0,  32'h0000_0000},
        // training finished: no filtering
        '{STEP_CFG,   CFG_TRAIN_DONE, ACT_READ_EM, 10'd0,   5'd0,  5'd0,  5'd0,  32'd1},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_EM, 10'd1023, 5'd31, 5'd0,  5'd0,  32'h7FFF_FFFF},
        '{STEP_CFG,   CFG_TRAIN_DONE, ACT_READ_EM, 10'd0,   5'd0,  5'd0,  5'd0,  32'd0},
        '{STEP_CFG,   CFG_THRESHOLD, ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'd0},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_TR, 10'd0,    5'd0,  5'd0,  5'd0,  32'h8000_0000},
        // highest threshold hides everything counted here
        '{STEP_CFG,   CFG_THRESHOLD, ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'h0000_FFFF},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_EM, 10'd5,    5'd3,  5'd0,  5'd0,  32'h0000_0000},
        '{STEP_ITEM,  CFG_FILTER_ON, ACT_UPD_TR,  10'd0,    5'd7,  5'd9,  5'd31, 32'h0001_2345},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_TR, 10'd0,    5'd7,  5'd9,  5'd31, 32'h0000_0000},
        '{STEP_CFG,   CFG_FILTER_ON, ACT_READ_EM, 10'd0,    5'd0,  5'd0,  5'd0,  32'd0},
        '{STEP_CHECK, CFG_FILTER_ON, ACT_READ_TR, 10'd0,    5'd7,  5'd9,  5'd31, 32'h0002_468A}
    };

    localparam logic [LABEL_BITS-1:0]    LABEL_POOL [5] = '{5'd0, 5'd1, 5'd2, 5'd30, 5'd31};
    localparam logic [TEMPLATE_BITS-1:0] TMPL_POOL  [4] = '{10'd0, 10'd1, 10'd2, 10'd1023};

    // DUT pins; every input holds a known value from time zero
    logic                          clk;
    logic                          rst_n         = 1'b0;
    logic                          start         = 1'b0;
    logic                          busy;
    logic [ACTION_BITS-1:0]        action        = '0;
    logic [TEMPLATE_BITS-1:0]      template_index = '0;
    logic [LABEL_BITS-1:0]         cur_label     = '0;
    logic [LABEL_BITS-1:0]         prev_label    = '0;
    logic [LABEL_BITS-1:0]         prev_prev_label = '0;
    logic signed [DELTA_BITS-1:0]  delta         = '0;
    logic                          score_valid;
    logic signed [SCORE_BITS-1:0]  score;
    logic                          cfg_we        = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data      = '0;

    // Predictor state: both tables and the register copy, zero after reset
    bit signed [WEIGHT_BITS_DEF-1:0] em_weight [EM_DEPTH];
    bit [CNT_BITS-1:0]               em_count  [EM_DEPTH];
    bit signed [WEIGHT_BITS_DEF-1:0] tr_weight [TR_DEPTH];
    bit [CNT_BITS-1:0]               tr_count  [TR_DEPTH];
    bit                              cfg_filter_on;
    bit                              cfg_train_done;
    bit [CNT_BITS-1:0]               cfg_threshold;
    bit [ORDER_BITS-1:0]             cfg_order;

    logic signed [SCORE_BITS-1:0] pending_scores [$];
    logic signed [SCORE_BITS-1:0] oldest_score;
    int                           mismatches  = 0;
    int                           cycle_count = 0;

    perceptron_weight_table i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (action),
        .i_template_index (template_index),
        .i_cur_label      (cur_label),
        .i_prev_label     (prev_label),
        .i_prev_prev_label(prev_prev_label),
        .i_delta          (delta),
        .o_valid          (score_valid),
        .o_score          (score),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_q16(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // A weight as a read sees it: hidden while counting, before training is done, and under threshold
    function automatic longint visible(bit signed [WEIGHT_BITS_DEF-1:0] w, bit [CNT_BITS-1:0] c);
        if (cfg_train_done || !cfg_filter_on) return longint'(w);
        if (c < cfg_threshold) return 0;
        return longint'(w);
    endfunction

    // Applies one item to the tables; reads give the score they should return
    task automatic apply_to_tables(input t_table_op op, output bit gives_score,
                                   output logic signed [SCORE_BITS-1:0] expected);
        int     em_at;
        int     ctx_at [3];
        int     n_ctx;
        longint acc;
        em_at     = int'(op.tmpl) * LBL + int'(op.cur);
        ctx_at[0] = TR_BASE + LBL * LBL + int'(op.cur);
        ctx_at[1] = TR_BASE + int'(op.prev) * LBL + int'(op.cur);
        ctx_at[2] = int'(op.pprev) * LBL * LBL + int'(op.prev) * LBL + int'(op.cur);
        n_ctx     = (cfg_order >= 2) ? 3 : int'(cfg_order) + 1;
        gives_score = 1'b0;
        expected    = '0;
        case (op.act)
            ACT_READ_EM: begin
                gives_score = 1'b1;
                expected    = SCORE_BITS'(clamp_q16(visible(em_weight[em_at],
                                                            em_count[em_at])));
            end
            ACT_UPD_EM: begin
                em_weight[em_at] = WEIGHT_BITS_DEF'(clamp_q16(longint'(em_weight[em_at])
                                                              + longint'(op.delta)));
                if (cfg_filter_on && em_count[em_at] != '1)
                    em_count[em_at] += 1'b1;
            end
            ACT_READ_TR: begin
                acc = 0;
                for (int k = 0; k < n_ctx; k++)
                    acc += visible(tr_weight[ctx_at[k]], tr_count[ctx_at[k]]);
                gives_score = 1'b1;
                expected    = SCORE_BITS'(clamp_q16(acc));
            end
            default: begin
                for (int k = 0; k < n_ctx; k++) begin
                    tr_weight[ctx_at[k]] = WEIGHT_BITS_DEF'(clamp_q16(
                        longint'(tr_weight[ctx_at[k]]) + longint'(op.delta)));
                    if (cfg_filter_on && tr_count[ctx_at[k]] != '1)
                        tr_count[ctx_at[k]] += 1'b1;
                end
            end
        endcase
    endtask

    // Drives one item and holds it until the transfer; start stays high after
    // it, so back-to-back items are offered with no gap on start.
    task automatic issue(input t_table_op op, input bit typed,
                         input logic signed [SCORE_BITS-1:0] typed_score);
        bit                           gives_score;
        logic signed [SCORE_BITS-1:0] expected;
        @(negedge clk);
        start           <= 1'b1;
        action          <= op.act;
        template_index  <= op.tmpl;
        cur_label       <= op.cur;
        prev_label      <= op.prev;
        prev_prev_label <= op.pprev;
        delta           <= op.delta;
        @(posedge clk);
        while (busy) @(posedge clk);
        apply_to_tables(op, gives_score, expected);
        if (gives_score)
            pending_scores.insert(pending_scores.size(), typed ? typed_score : expected);
    endtask

    task automatic pause(input int cycles);
        repeat (cycles) @(negedge clk) start <= 1'b0;
    endtask

    // Idle the block: no item offered, every score back, last update retired
    task automatic settle();
        @(negedge clk) start <= 1'b0;
        while (pending_scores.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_FILTER_ON:  cfg_filter_on  = val[0];
            CFG_TRAIN_DONE: cfg_train_done = val[0];
            CFG_THRESHOLD:  cfg_threshold  = val;
            default:        cfg_order      = val[ORDER_BITS-1:0];
        endcase
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    // Mostly a small pool of addresses so that reads meet earlier updates
    function automatic t_table_op random_op();
        t_table_op op;
        op.act   = t_action'($urandom_range(0, 3));
        op.tmpl  = ($urandom_range(0, 9) < 8) ? TMPL_POOL[$urandom_range(0, 3)]
                                              : TEMPLATE_BITS'($urandom);
        op.cur   = ($urandom_range(0, 9) < 8) ? LABEL_POOL[$urandom_range(0, 4)]
                                              : LABEL_BITS'($urandom);
        op.prev  = ($urandom_range(0, 9) < 8) ? LABEL_POOL[$urandom_range(0, 4)]
                                              : LABEL_BITS'($urandom);
        op.pprev = ($urandom_range(0, 9) < 8) ? LABEL_POOL[$urandom_range(0, 4)]
                                              : LABEL_BITS'($urandom);
        case ($urandom_range(0, 9))
            0:       op.delta = 32'sh7FFF_FFFF;
            1:       op.delta = 32'sh8000_0000;
            2:       op.delta = '0;
            3, 4, 5: op.delta = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            default: op.delta = $urandom;
        endcase
        return op;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [SCORE_BITS-1:0] got,
                                   input logic signed [SCORE_BITS-1:0] want);
        $display("mismatch at cycle %0d: %s, got %h expected %h",
                 cycle_count, what, got, want);
        mismatches++;
    endtask

    // Scores cannot be held off, so each strobe is one transfer to check
    always @(posedge clk) begin
        if (rst_n && score_valid) begin
            if (pending_scores.size() == 0) begin
                report_mismatch("score with nothing outstanding", score, '0);
            end else begin
                oldest_score = pending_scores.pop_front();
                if (score !== oldest_score)
                    report_mismatch("score", score, oldest_score);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        t_step                  row;
        t_table_op              op;
        bit                     idle_on;
        logic [CNT_BITS-1:0]    thr;
        logic [ORDER_BITS-1:0]  ord;
        bit                     fil;
        bit                     done;

        // One reset at the start; the clearing sweep behind it shows up as busy
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            row      = DIRECTED[i];
            op.act   = row.act;
            op.tmpl  = row.tmpl;
            op.cur   = row.cur;
            op.prev  = row.prev;
            op.pprev = row.pprev;
            op.delta = (row.kind == STEP_ITEM) ? $signed(row.value) : $signed($urandom);
            case (row.kind)
                STEP_CFG: begin
                    settle();
                    write_reg(row.idx, row.value[CFG_DATA_BITS-1:0]);
                end
                STEP_ITEM:  issue(op, 1'b0, '0);
                default:    issue(op, 1'b1, $signed(row.value));
            endcase
        end

        // Random phases, each under its own register setting; sender gaps
        // everywhere but the last phase
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin fil = 1'b1; done = 1'b0; thr = 16'd1;     ord = 2'd2; end
                1: begin fil = 1'b1; done = 1'b0; thr = 16'd3;     ord = 2'd1; end
                2: begin fil = 1'b0; done = 1'b1; thr = CNT_BITS'($urandom); ord = 2'd2; end
                3: begin fil = 1'b1; done = 1'b1; thr = 16'hFFFF;  ord = 2'd3; end
                4: begin fil = 1'b1; done = 1'b0; thr = 16'hFFFF;  ord = 2'd0; end
                default: begin
                    fil  = 1'($urandom_range(0, 1));
                    done = 1'b0;
                    thr  = CNT_BITS'($urandom_range(0, 4));
                    ord  = ORDER_BITS'($urandom_range(0, 3));
                end
            endcase
            settle();
            write_reg(CFG_FILTER_ON, {15'd0, fil});
            write_reg(CFG_TRAIN_DONE, {15'd0, done});
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_ORDER, {14'd0, ord});
            idle_on = (ph != PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                issue(random_op(), 1'b0, '0);
                if (idle_on && $urandom_range(0, 3) == 0)
                    pause($urandom_range(1, 11));
            end
        end

        settle();
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
